### hw/rtl/mtkl_pkg.sv
`timescale 1ns / 1ps
// Shared types, LCD command codes and key group tables for the multi-tap
// keypad to LCD text entry block. No dependencies.
package mtkl_pkg;

    localparam logic [7:0] CMD_CURSOR_BACK = 8'h10;
    localparam logic [7:0] CMD_CURSOR_FWD  = 8'h14;
    localparam logic [7:0] CMD_SHIFT       = 8'h18;

    localparam logic [3:0] KEY_CURSOR_BACK = 4'd3;
    localparam logic [3:0] KEY_CURSOR_FWD  = 4'd7;
    localparam logic [3:0] KEY_EXIT        = 4'd15;

    // Default depth of the output beat buffer; a power of two, at least 2.
    localparam int OBUF_DEPTH_DEF = 4;

    typedef struct packed {
        logic       is_command;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Results of one tick: how many (0 to 2) and the beats in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_pair_t;

    // Number of characters in a key's group; zero for the command keys.
    function automatic logic [2:0] grp_len(input logic [3:0] key);
        logic [2:0] len;
        begin
            case (key)
                4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: len = 3'd4;
                4'd10, 4'd13:                                   len = 3'd3;
                4'd12, 4'd14:                                   len = 3'd1;
                default:                                        len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] grp_chr(input logic [3:0] key, input logic [1:0] idx);
        logic [7:0] chr;
        begin
            chr = 8'h00;
            case (key)
                4'd0:  chr = (idx == 2'd0) ? "a" : (idx == 2'd1) ? "b" : (idx == 2'd2) ? "c" : "1";
                4'd1:  chr = (idx == 2'd0) ? "d" : (idx == 2'd1) ? "e" : (idx == 2'd2) ? "f" : "2";
                4'd2:  chr = (idx == 2'd0) ? "g" : (idx == 2'd1) ? "h" : (idx == 2'd2) ? "i" : "3";
                4'd4:  chr = (idx == 2'd0) ? "j" : (idx == 2'd1) ? "k" : (idx == 2'd2) ? "l" : "4";
                4'd5:  chr = (idx == 2'd0) ? "m" : (idx == 2'd1) ? "n" : (idx == 2'd2) ? "o" : "5";
                4'd6:  chr = (idx == 2'd0) ? "p" : (idx == 2'd1) ? "q" : (idx == 2'd2) ? "r" : "6";
                4'd8:  chr = (idx == 2'd0) ? "s" : (idx == 2'd1) ? "t" : (idx == 2'd2) ? "u" : "7";
                4'd9:  chr = (idx == 2'd0) ? "v" : (idx == 2'd1) ? "w" : (idx == 2'd2) ? "x" : "8";
                4'd10: chr = (idx == 2'd0) ? "y" : (idx == 2'd1) ? "z" : (idx == 2'd2) ? "9" : 8'h00;
                4'd12: chr = (idx == 2'd0) ? "#" : 8'h00;
                4'd13: chr = (idx == 2'd0) ? "0" : (idx == 2'd1) ? "_" : (idx == 2'd2) ? " " : 8'h00;
                4'd14: chr = (idx == 2'd0) ? "*" : 8'h00;
                default: chr = 8'h00;
            endcase
            return chr;
        end
    endfunction

endpackage

### hw/rtl/mtkl_tap.sv
`timescale 1ns / 1ps
// Tap tracker: holds the key-hold state and turns one scanned tick into
// zero, one or two LCD beats. Depends on mtkl_pkg.
module mtkl_tap
    import mtkl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    input  logic       key_down,
    input  logic [3:0] key_code,
    output res_pair_t  res
);

    logic [3:0] held_key_reg, held_key_next;
    logic       holding_reg, holding_next;
    logic [1:0] tap_index_reg, tap_index_next;
    logic       entry_done_reg, entry_done_next;

    logic [2:0] len;
    logic [2:0] next_idx;

    assign len      = grp_len(key_code);
    assign next_idx = {1'b0, tap_index_reg} + 3'd1;

    always_comb
    begin
        held_key_next   = held_key_reg;
        holding_next    = holding_reg;
        tap_index_next  = tap_index_reg;
        entry_done_next = entry_done_reg;
        res             = '0;

        if (entry_done_reg)
        begin
            res.count  = 2'd1;
            res.first  = '{is_command: 1'b1, out_byte: CMD_SHIFT, last: 1'b1};
        end
        else if (!key_down)
        begin
            holding_next = 1'b0;
        end
        else if (len == 3'd0)
        begin
            holding_next   = 1'b1;
            held_key_next  = key_code;
            tap_index_next = 2'd0;
            if (key_code == KEY_EXIT)
            begin
                entry_done_next = 1'b1;
            end
            else
            begin
                res.count = 2'd1;
                res.first.is_command = 1'b1;
                res.first.last       = 1'b1;
                if (key_code == KEY_CURSOR_BACK)
                    res.first.out_byte = CMD_CURSOR_BACK;
                else if (key_code == KEY_CURSOR_FWD)
                    res.first.out_byte = CMD_CURSOR_FWD;
                else
                    res.first.out_byte = CMD_SHIFT;
            end
        end
        else if (holding_reg && held_key_reg == key_code && next_idx < len)
        begin
            // Same letter key still held: step back over the last character
            // and replace it with the next one of the group.
            tap_index_next = next_idx[1:0];
            res.count  = 2'd2;
            res.first  = '{is_command: 1'b1, out_byte: CMD_CURSOR_BACK, last: 1'b0};
            res.second = '{is_command: 1'b0, out_byte: grp_chr(key_code, next_idx[1:0]),
                           last: 1'b1};
        end
        else
        begin
            holding_next   = 1'b1;
            held_key_next  = key_code;
            tap_index_next = 2'd0;
            res.count  = 2'd1;
            res.first  = '{is_command: 1'b0, out_byte: grp_chr(key_code, 2'd0), last: 1'b1};
        end

        if (!tick_valid)
        begin
            held_key_next   = held_key_reg;
            holding_next    = holding_reg;
            tap_index_next  = tap_index_reg;
            entry_done_next = entry_done_reg;
            res.count       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg   <= '0;
            holding_reg    <= 1'b0;
            tap_index_reg  <= '0;
            entry_done_reg <= 1'b0;
        end
        else
        begin
            held_key_reg   <= held_key_next;
            holding_reg    <= holding_next;
            tap_index_reg  <= tap_index_next;
            entry_done_reg <= entry_done_next;
        end
    end

endmodule

### hw/rtl/mtkl_obuf.sv
`timescale 1ns / 1ps
// Output beat buffer: a small register FIFO taking up to two beats per cycle
// from the tap tracker, sending one per cycle while out_ready. Uses mtkl_pkg.
module mtkl_obuf
    import mtkl_pkg::*;
#(
    parameter int DEPTH = OBUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_pair_t  res,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_beat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_p1;
    logic            pop;

    assign room      = (count_reg <= CntW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_beat  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + PtrW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(res.count);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(res.count) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0)
            mem_reg[wr_ptr_reg] <= res.first;
        if (res.count == 2'd2)
            mem_reg[wr_ptr_p1] <= res.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/multitap_keypad_to_lcd_core.sv
`timescale 1ns / 1ps
// Multi-tap keypad to character LCD text entry. Each input beat is one
// hold-check tick with the scanned key state; each output beat is one LCD
// command or data byte. A tick is taken in any cycle in which the output
// buffer has room for two beats; its beats are registered into the buffer
// behind any beats already waiting. The output sends one beat per cycle
// while m_tready is high, so ticks that give one beat flow at one per
// cycle. The buffer depth sets how much output stall the input rides
// through. Depends on mtkl_pkg, mtkl_tap and mtkl_obuf.
module multitap_keypad_to_lcd_core
    import mtkl_pkg::*;
#(
    parameter int OBUF_DEPTH = OBUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] key_down, [4:1] key_code, [7:5] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] is_command
    output logic       m_tlast
);

    res_pair_t res;
    result_t   beat;
    logic      room;

    assign s_tready = room;

    mtkl_tap u_tap (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (s_tvalid && room),
        .key_down   (s_tdata[0]),
        .key_code   (s_tdata[4:1]),
        .res        (res)
    );

    mtkl_obuf #(
        .DEPTH (OBUF_DEPTH)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (beat)
    );

    assign m_tdata = beat.out_byte;
    assign m_tuser = beat.is_command;
    assign m_tlast = beat.last;

endmodule

### hw/rtl/mtkl_chk.sv
`timescale 1ns / 1ps
// Port checker for the keypad to LCD core, bound to the top level.
// Depends on mtkl_pkg and multitap_keypad_to_lcd_core.
module mtkl_chk
    import mtkl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled output beat holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Only a cursor-back command opens a two-beat group.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata == CMD_CURSOR_BACK)
        else $error("non-final beat is not cursor back");

    // The character that completes the group is ready right after it.
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser && m_tlast)
        else $error("cursor back not followed by a final character");

    // Characters always end their tick.
    a_chr_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("character beat without last");

    // Only the three cursor and shift codes are sent as commands.
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == CMD_CURSOR_BACK || m_tdata == CMD_CURSOR_FWD
            || m_tdata == CMD_SHIFT)
        else $error("unknown command byte");

endmodule

bind multitap_keypad_to_lcd_core mtkl_chk u_chk (.*);
